// File: rtl/handheld_power_housekeeper_macros.svh
// assertion macros for the handheld power housekeeper
// used by rtl/handheld_power_housekeeper.sv, no other dependencies
`ifndef HANDHELD_POWER_HOUSEKEEPER_MACROS_SVH
`define HANDHELD_POWER_HOUSEKEEPER_MACROS_SVH
`ifndef SYNTHESIS
// clocked assertion with asynchronous active-low reset as disable
`define HPH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked assertion checked during reset as well
`define HPH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPH_ASSERT(lbl, clk, rst_n, prop, msg)
`define HPH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/hph_pkg.sv
// types and constants of the handheld power housekeeper
// no dependencies; used by rtl/handheld_power_housekeeper.sv
`timescale 1ns / 1ps

package hph_pkg;

	// configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WARN       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MID        = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CRITICAL   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_LIMIT = 3'd4;

	// register reset values
	localparam logic [7:0]  LONG_PRESS_RESET = 8'd15;
	localparam logic [11:0] WARN_RESET       = 12'd2234;
	localparam logic [11:0] MID_RESET        = 12'd2172;
	localparam logic [11:0] CRITICAL_RESET   = 12'd2110;
	localparam logic [15:0] IDLE_LIMIT_RESET = 16'd6000;

	// widest threshold field of the register map
	localparam int THR_FIELD_BITS = 12;

	// phase codes
	localparam logic [1:0] PH_KEY  = 2'd0;
	localparam logic [1:0] PH_BATT = 2'd1;
	localparam logic [1:0] PH_IDLE = 2'd2;

	// shutdown kinds
	localparam logic [1:0] SD_NONE    = 2'd0;
	localparam logic [1:0] SD_KEY     = 2'd1;
	localparam logic [1:0] SD_BATTERY = 2'd2;
	localparam logic [1:0] SD_IDLE    = 2'd3;

	// key counter and blink counter constants
	localparam logic [7:0] KEY_DISARMED  = 8'd255;
	localparam logic [3:0] BLINK_PERIOD  = 4'd10;
	localparam logic [3:0] BLINK_HALF    = 4'd5;
	localparam logic [3:0] BLINK_MID_ON  = 4'd2;
	localparam logic [3:0] BLINK_MID_ON2 = 4'd7;

	// housekeeping state
	typedef struct packed {
		logic [1:0]  phase;
		logic [7:0]  key_cnt;
		logic [3:0]  blink_cnt;
		logic [15:0] idle_cnt;
		logic        normal;
		logic        act_seen;
		logic        led;
		logic [1:0]  halt;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:     PH_KEY,
		key_cnt:   KEY_DISARMED,
		blink_cnt: 4'd0,
		idle_cnt:  16'd0,
		normal:    1'b1,
		act_seen:  1'b0,
		led:       1'b1,
		halt:      SD_NONE
	};

endpackage

// File: rtl/handheld_power_housekeeper.sv
// top level of the handheld power housekeeper: tick logic and register file
// depends on rtl/hph_pkg.sv and rtl/handheld_power_housekeeper_macros.svh
`timescale 1ns / 1ps
`include "handheld_power_housekeeper_macros.svh"

// Handheld power housekeeper. Every input beat is one housekeeping tick and
// yields exactly one result beat (LED level, send enable, shutdown kind).
// A tick is captured in an input register and worked, once the result
// register frees, by short compare-and-count logic into the state register,
// which also drives the result. One tick is taken every cycle while
// out_ready is high, limited only by the single state update per cycle.
// in_ready stays high while a result waits unless both the input and the
// result register are full. After any shutdown request the state freezes
// and every further tick returns the frozen result with the LED off.
// Configuration writes are always ready and should be made while idle.
module handheld_power_housekeeper #(
	parameter int BATT_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hph_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [hph_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	// tick input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  key_pressed,
	input  logic [BATT_BITS-1:0]                  battery_level,
	input  logic                                  activity,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  power_led,
	output logic                                  send_enabled,
	output logic [1:0]                            shutdown_kind
);

	// stored threshold width: the register field, cut to the sample width
	localparam int THR_BITS = (BATT_BITS < hph_pkg::THR_FIELD_BITS) ?
		BATT_BITS : hph_pkg::THR_FIELD_BITS;

	// configuration registers
	logic [7:0]          long_press_q;
	logic [THR_BITS-1:0] warn_q;
	logic [THR_BITS-1:0] mid_q;
	logic [THR_BITS-1:0] critical_q;
	logic [15:0]         idle_limit_q;

	// input stage
	logic                 s1_valid;
	logic                 key_s1;
	logic [BATT_BITS-1:0] batt_s1;
	logic                 act_s1;

	// state and result
	hph_pkg::state_t st_q;
	hph_pkg::state_t st_next;
	logic            out_valid_q;
	logic            advance;

	// next-state temporaries
	logic [1:0]  phase_n;
	logic        act_n;
	logic [7:0]  key_inc;
	logic [3:0]  blink_inc;
	logic [3:0]  blink_n;
	logic [15:0] idle_inc;

	assign cfg_ready = 1'b1;

	// register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= hph_pkg::LONG_PRESS_RESET;
			warn_q       <= THR_BITS'(hph_pkg::WARN_RESET);
			mid_q        <= THR_BITS'(hph_pkg::MID_RESET);
			critical_q   <= THR_BITS'(hph_pkg::CRITICAL_RESET);
			idle_limit_q <= hph_pkg::IDLE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hph_pkg::REG_LONG_PRESS: long_press_q <= cfg_data[7:0];
				hph_pkg::REG_WARN:       warn_q       <= cfg_data[THR_BITS-1:0];
				hph_pkg::REG_MID:        mid_q        <= cfg_data[THR_BITS-1:0];
				hph_pkg::REG_CRITICAL:   critical_q   <= cfg_data[THR_BITS-1:0];
				hph_pkg::REG_IDLE_LIMIT: idle_limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline flow: the input stage moves on when the result register frees
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !s1_valid || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1  <= key_pressed;
			batt_s1 <= battery_level;
			act_s1  <= activity;
		end
	end

	// tick work: one phase of the rotation per beat
	always_comb begin
		st_next   = st_q;
		phase_n   = (st_q.phase >= hph_pkg::PH_IDLE) ? hph_pkg::PH_KEY : st_q.phase + 2'd1;
		act_n     = st_q.act_seen | act_s1;
		key_inc   = st_q.key_cnt + 8'd1;
		blink_inc = st_q.blink_cnt + 4'd1;
		blink_n   = (blink_inc >= hph_pkg::BLINK_PERIOD) ? 4'd0 : blink_inc;
		idle_inc  = st_q.idle_cnt + 16'd1;
		if (st_q.halt == hph_pkg::SD_NONE) begin
			st_next.phase    = phase_n;
			st_next.act_seen = act_n;
			unique case (phase_n)
				hph_pkg::PH_KEY: begin
					// held key count, armed only after a release
					if (!key_s1) begin
						st_next.key_cnt = 8'd0;
					end else if (st_q.key_cnt != hph_pkg::KEY_DISARMED) begin
						st_next.key_cnt = key_inc;
						if (key_inc >= long_press_q) begin
							st_next.led  = 1'b0;
							st_next.halt = hph_pkg::SD_KEY;
						end
					end
				end
				hph_pkg::PH_BATT: begin
					// battery thresholds and blink pattern
					st_next.blink_cnt = blink_n;
					if (batt_s1 < BATT_BITS'(warn_q)) begin
						if (batt_s1 < BATT_BITS'(critical_q)) begin
							st_next.led  = 1'b0;
							st_next.halt = hph_pkg::SD_BATTERY;
						end else if (batt_s1 < BATT_BITS'(mid_q)) begin
							st_next.led = (blink_n < hph_pkg::BLINK_MID_ON) ||
								(blink_n >= hph_pkg::BLINK_HALF && blink_n < hph_pkg::BLINK_MID_ON2);
						end else begin
							st_next.led = blink_n < hph_pkg::BLINK_HALF;
						end
					end else begin
						st_next.led = 1'b1;
					end
				end
				default: begin
					// inactivity tracking: standby first, then shutdown
					if (act_n) begin
						st_next.act_seen = 1'b0;
						st_next.idle_cnt = 16'd0;
						st_next.normal   = 1'b1;
					end else begin
						st_next.idle_cnt = idle_inc;
						if (idle_inc > idle_limit_q) begin
							if (st_q.normal) begin
								st_next.idle_cnt = 16'd0;
								st_next.normal   = 1'b0;
							end else begin
								st_next.led  = 1'b0;
								st_next.halt = hph_pkg::SD_IDLE;
							end
						end
					end
				end
			endcase
		end
	end

	// state register doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= hph_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid;
			if (s1_valid) begin
				st_q <= st_next;
			end
		end
	end

	// result beat
	assign out_valid     = out_valid_q;
	assign power_led     = st_q.led;
	assign send_enabled  = st_q.normal;
	assign shutdown_kind = st_q.halt;

	// checks
	`HPH_ASSERT(a_halt_frozen, clk, arst_n, (st_q.halt != hph_pkg::SD_NONE) |=> $stable(st_q), "state changed after shutdown")
	`HPH_ASSERT(a_halt_led_off, clk, arst_n, (st_q.halt != hph_pkg::SD_NONE) |-> !st_q.led, "led on after shutdown")
	`HPH_ASSERT(a_blink_range, clk, arst_n, st_q.blink_cnt < hph_pkg::BLINK_PERIOD, "blink counter out of range")
	`HPH_ASSERT(a_stalled_tick_kept, clk, arst_n, (s1_valid && !advance) |=> s1_valid, "stalled tick dropped")

endmodule
